>>> rtl/pmu_pkg.sv
// Package: shared types, constants and codes of the pulse period speed meter.
`timescale 1ns / 1ps
`default_nettype none
package pmu_pkg;

    localparam int CAPTURE_W   = 16;
    localparam int NUMER_W     = 32;
    localparam int INTERVAL_W  = 8;
    localparam int SPEED_W     = 20;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 6;
    localparam int BCD_W       = DIGIT_W * NUM_DIGITS;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(999999);

    localparam logic [NUMER_W-1:0]    NUMER_RESET    = NUMER_W'(58437400);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(101);

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUMERATOR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_INTERVAL = CFG_IDX_W'(1);

    // Iterative unit step counts
    localparam int STEP_W    = 5;
    localparam int DIV_STEPS = NUMER_W;
    localparam int BCD_STEPS = SPEED_W;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [CAPTURE_W-1:0] interval;
        logic                 is_zero;
        logic                 update;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SAT,
        BK_BCD,
        BK_DONE
    } back_state_t;

endpackage
`default_nettype wire

>>> rtl/pmu_front.sv
// Front end: input transfer, elapsed tick count and display update pacing.
`timescale 1ns / 1ps
`default_nettype none
module pmu_front
    import pmu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [INTERVAL_W-1:0] display_interval,
    input  wire queue_status_t         q_status,
    output logic                       q_push,
    output queue_entry_t               q_entry
);

    logic [CAPTURE_W-1:0]  last_capture_reg, last_capture_next;
    logic [INTERVAL_W-1:0] pulse_count_reg, pulse_count_next;
    logic [CAPTURE_W-1:0]  now;
    logic [CAPTURE_W-1:0]  interval;
    logic                  update;

    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    assign now      = s_axis_tdata[CAPTURE_W-1:0];
    assign interval = now - last_capture_reg;   // wraps modulo 2^16
    assign update   = (pulse_count_reg >= display_interval);

    always_comb
    begin
        q_entry.interval = interval;
        q_entry.is_zero  = (interval == '0);
        q_entry.update   = update;
    end

    always_comb
    begin
        last_capture_next = last_capture_reg;
        pulse_count_next  = pulse_count_reg;
        if (q_push)
        begin
            last_capture_next = now;
            pulse_count_next  = update ? INTERVAL_W'(1) : pulse_count_reg + INTERVAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            pulse_count_reg  <= '0;
        end
        else
        begin
            last_capture_reg <= last_capture_next;
            pulse_count_reg  <= pulse_count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/pmu_queue.sv
// Two-entry queue decoupling the front end from the divide/convert back end.
`timescale 1ns / 1ps
`default_nettype none
module pmu_queue
    import pmu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire queue_entry_t push_entry,
    input  wire logic         pop,
    output queue_entry_t      head,
    output queue_status_t     status
);

    queue_entry_t       mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

>>> rtl/pmu_back.sv
// Back end: radix-2 divider, saturation, binary-to-BCD converter, output register.
`timescale 1ns / 1ps
`default_nettype none
module pmu_back
    import pmu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [NUMER_W-1:0]    speed_numerator,
    input  wire queue_entry_t          q_head,
    input  wire queue_status_t         q_status,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    back_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CAPTURE_W-1:0] div_reg;
    logic [CAPTURE_W-1:0] rem_reg;
    logic [NUMER_W-1:0]   quo_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [SPEED_W-1:0]   bin_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic                 sat_reg;
    logic                 upd_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                 start;
    logic                 load_out;
    logic                 step_last_div;
    logic                 step_last_bcd;

    logic [CAPTURE_W:0]   trial;
    logic                 fits;
    logic [BCD_W-1:0]     bcd_adj;

    assign step_last_div = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign step_last_bcd = (step_reg == STEP_W'(BCD_STEPS - 1));

    // one restoring divide step
    assign trial = {rem_reg, quo_reg[NUMER_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    // add-3 on every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_status.empty)
                    state_next = q_head.is_zero ? BK_BCD : BK_DIV;
            BK_DIV:
                if (step_last_div)
                    state_next = BK_SAT;
            BK_SAT:
                state_next = BK_BCD;
            BK_BCD:
                if (step_last_bcd)
                    state_next = BK_DONE;
            BK_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: start    = !q_status.empty;
            BK_DONE: load_out = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    assign q_pop = start;

    always_comb
    begin
        step_next = '0;
        if ((state_reg == BK_DIV && !step_last_div) || (state_reg == BK_BCD && !step_last_bcd))
            step_next = step_reg + STEP_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= q_head.interval;
            rem_reg <= '0;
            quo_reg <= speed_numerator;
            upd_reg <= q_head.update;
            bcd_reg <= '0;
            sat_reg <= q_head.is_zero;
            speed_reg <= SPEED_MAX;
            bin_reg   <= SPEED_MAX;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg <= fits ? trial[CAPTURE_W-1:0] - div_reg : trial[CAPTURE_W-1:0];
            quo_reg <= {quo_reg[NUMER_W-2:0], fits};
        end
        else if (state_reg == BK_SAT)
        begin
            if (quo_reg > NUMER_W'(SPEED_MAX))
            begin
                sat_reg   <= 1'b1;
                speed_reg <= SPEED_MAX;
                bin_reg   <= SPEED_MAX;
            end
            else
            begin
                sat_reg   <= 1'b0;
                speed_reg <= quo_reg[SPEED_W-1:0];
                bin_reg   <= quo_reg[SPEED_W-1:0];
            end
        end
        else if (state_reg == BK_BCD)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[SPEED_W-1]};
            bin_reg <= {bin_reg[SPEED_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= {2'b00, upd_reg, bcd_reg[3:0], bcd_reg[7:4], bcd_reg[11:8],
                             bcd_reg[15:12], bcd_reg[19:16], bcd_reg[23:20],
                             sat_reg, speed_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

>>> rtl/pulse_period_speed_meter_unit.sv
// Top level: config registers, front end, queue and back end of the speed meter.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[15:0] capture_time
//  m_axis    out  m_axis_tvalid/tready        tdata[45:0] speed, flags, six BCD digits
//  cfg       in   cfg_valid/cfg_ready         cfg_index (0 numerator, 1 interval), cfg_data
//
// Each capture goes through the back end in order: a queue pop, the radix-2
// divider (one quotient bit a cycle), saturation, the shift-add-3 BCD converter
// and an output register load; a zero interval skips divider and saturation. The
// back end ends one capture before it takes the next, so its loop sets the rate.
// Reset (rst_n low, asynchronous) clears the last capture, the pulse counter, the
// queue and the output valid, and loads the config reset values.
// The two-entry queue lets captures be taken while the back end works; the output
// register holds a finished transfer while m_axis_tready is low and the back end
// waits in its final state until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module pulse_period_speed_meter_unit
    import pmu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] capture_time
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [19:0] speed_e4, [20] saturated, [24:21] tens_digit, [28:25] ones_digit,
    // [32:29] tenths_digit, [36:33] hundredths_digit, [40:37] thousandths_digit,
    // [44:41] myriadths_digit, [45] display_update, [47:46] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NUMER_W-1:0]    numer_reg, numer_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;

    queue_status_t q_status;
    queue_entry_t  q_push_entry;
    queue_entry_t  q_head;
    logic          q_push;
    logic          q_pop;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        numer_next    = numer_reg;
        interval_next = interval_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPEED_NUMERATOR:  numer_next    = cfg_data[NUMER_W-1:0];
                REG_DISPLAY_INTERVAL: interval_next = cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numer_reg    <= NUMER_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            numer_reg    <= numer_next;
            interval_reg <= interval_next;
        end
    end

    pmu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .display_interval (interval_reg),
        .q_status         (q_status),
        .q_push           (q_push),
        .q_entry          (q_push_entry)
    );

    pmu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    pmu_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .speed_numerator (numer_reg),
        .q_head          (q_head),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/pmu_checker.sv
// Port-level checker for the speed meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pmu_checker
    import pmu_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // saturation always reports the ceiling speed
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:0] == SPEED_MAX)
        else $error("saturated without ceiling speed");

    // speed never above the ceiling
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:0] <= SPEED_MAX)
        else $error("speed above ceiling");

    // every digit is decimal
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:21] <= 4'd9 && m_axis_tdata[28:25] <= 4'd9 &&
                          m_axis_tdata[32:29] <= 4'd9 && m_axis_tdata[36:33] <= 4'd9 &&
                          m_axis_tdata[40:37] <= 4'd9 && m_axis_tdata[44:41] <= 4'd9)
        else $error("digit out of range");

endmodule

bind pulse_period_speed_meter_unit pmu_checker u_pmu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the pulse period speed meter, with its own speed predictor.
`timescale 1ns / 1ps
module tb
    import pmu_pkg::*;
;

    // No transfer on any channel for this many cycles means the block hung.
    // The slowest capture is one back end pass plus short stalls on both sides,
    // so this is far beyond any correct gap.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 105;

    // One output transfer, laid out as m_axis_tdata[45:0] (first member is the MSB)
    typedef struct packed {
        logic               display_update;
        logic [DIGIT_W-1:0] myriadths;
        logic [DIGIT_W-1:0] thousandths;
        logic [DIGIT_W-1:0] hundredths;
        logic [DIGIT_W-1:0] tenths;
        logic [DIGIT_W-1:0] ones;
        logic [DIGIT_W-1:0] tens;
        logic               saturated;
        logic [SPEED_W-1:0] speed_e4;
    } speed_reading_t;

    localparam int READING_W = $bits(speed_reading_t);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // [15:0] capture_time
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [45:0] speed_reading_t, [47:46] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pulse_period_speed_meter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state: its own copy of the registers and of the block's state
    logic [NUMER_W-1:0]    numer_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [CAPTURE_W-1:0]  prev_capture;
    logic [INTERVAL_W-1:0] pulses_since_update;

    speed_reading_t        pending_readings[$];  // predicted, not yet seen on m_axis
    logic [CAPTURE_W-1:0]  stim_time = '0;       // last capture value sent
    bit                    idle_on = 1'b1;       // random gaps/stalls enabled
    int                    error_count = 0;
    int                    idle_cycles = 0;
    int                    ready_hold = 0;

    // Speed for one capture: elapsed ticks mod 2^16, numerator / ticks, saturate
    // at 99.9999 mph (zero ticks included), then split into six decimal digits.
    // The display flag fires once the pulse count has reached the interval.
    function automatic speed_reading_t predict_reading(input logic [CAPTURE_W-1:0] capture);
        speed_reading_t       r;
        logic [CAPTURE_W-1:0] ticks;
        int unsigned          speed;
        int unsigned          whole;
        int unsigned          frac;
        r = '0;
        ticks = capture - prev_capture;
        prev_capture = capture;
        if (ticks == '0)
        begin
            speed = 32'(SPEED_MAX);
            r.saturated = 1'b1;
        end
        else
        begin
            speed = numer_reg / NUMER_W'(ticks);
            if (speed > SPEED_MAX)
            begin
                speed = 32'(SPEED_MAX);
                r.saturated = 1'b1;
            end
        end
        whole = speed / 10000;
        frac = speed % 10000;
        r.speed_e4    = SPEED_W'(speed);
        r.tens        = DIGIT_W'((whole / 10) % 10);
        r.ones        = DIGIT_W'(whole % 10);
        r.tenths      = DIGIT_W'((frac / 1000) % 10);
        r.hundredths  = DIGIT_W'((frac / 100) % 10);
        r.thousandths = DIGIT_W'((frac / 10) % 10);
        r.myriadths   = DIGIT_W'(frac % 10);
        if (pulses_since_update >= interval_reg)
        begin
            r.display_update = 1'b1;
            pulses_since_update = '0;
        end
        pulses_since_update = pulses_since_update + INTERVAL_W'(1);
        return r;
    endfunction

    // Random tick delta: zero, short, medium or anywhere on the 16-bit circle
    function automatic logic [CAPTURE_W-1:0] random_ticks();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return CAPTURE_W'($urandom_range(1, 255));
            3, 4:    return CAPTURE_W'($urandom_range(256, 4095));
            default: return CAPTURE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // One capture transfer, sent delta ticks after the previous one. tvalid stays
    // high after a transfer, so back-to-back items drop it in between only for a random gap.
    task automatic send_ticks(input logic [CAPTURE_W-1:0] delta);
        stim_time = stim_time + delta;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stim_time;
        do @(posedge clk); while (!s_axis_tready);
        pending_readings.push_back(predict_reading(stim_time));
    endtask

    // Stop sending and let every outstanding reading come out
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SPEED_NUMERATOR:  numer_reg = value;
            REG_DISPLAY_INTERVAL: interval_reg = value[INTERVAL_W-1:0];
            default: ;
        endcase
    endtask

    // Both registers, written only once the block has gone idle
    task automatic configure(input logic [NUMER_W-1:0] numer, input logic [INTERVAL_W-1:0] every);
        wait_for_idle();
        write_reg(REG_SPEED_NUMERATOR, numer);
        write_reg(REG_DISPLAY_INTERVAL, CFG_DATA_W'(every));
        cfg_valid <= 1'b0;
    endtask

    // Reset values: first pulse measured from zero, zero interval, saturation
    // just above and just below the limit, 16-bit wrap and the longest interval.
    task automatic test_capture_edges();
        send_ticks(16'd1000);      // from the reset capture of 0
        send_ticks(16'd0);         // zero interval
        send_ticks(16'd58);        // 1007541 -> saturates
        send_ticks(16'd59);        // 990464, just under the limit
        send_ticks(16'd64418);     // up to 0xFFFF
        send_ticks(16'd1);         // wraps to 0x0000
        send_ticks(16'hFFFF);      // longest interval
    endtask

    // Numerator extremes: exact limit, full scale around the limit, zero
    task automatic test_numerator_extremes();
        configure(NUMER_W'(999999), INTERVAL_RESET);
        send_ticks(16'd1);         // exactly 99.9999, not saturated
        configure('1, INTERVAL_RESET);
        send_ticks(16'd4295);      // 999992
        send_ticks(16'd4294);      // saturates
        send_ticks(16'hFFFF);
        configure('0, INTERVAL_RESET);
        send_ticks(16'd1);         // zero speed
        send_ticks(16'd0);         // zero interval still saturates
    endtask

    // Display flag: short interval, zero interval (every pulse), and an interval
    // lowered below the running count, which fires on the next pulse.
    task automatic test_display_interval();
        configure(NUMER_RESET, INTERVAL_W'(3));
        repeat (5) send_ticks(random_ticks());
        configure(NUMER_RESET, INTERVAL_W'(0));
        repeat (2) send_ticks(random_ticks());
        configure(NUMER_RESET, INTERVAL_W'(8));
        repeat (5) send_ticks(random_ticks());
        configure(NUMER_RESET, INTERVAL_W'(2));
        repeat (2) send_ticks(random_ticks());
    endtask

    // Random captures across several register settings; the last phase runs
    // with no gaps or stalls at all.
    task automatic test_random_traffic();
        logic [NUMER_W-1:0]    numer;
        logic [INTERVAL_W-1:0] every;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    numer = NUMER_RESET;
                    every = INTERVAL_RESET;
                end
                1:
                begin
                    numer = '1;
                    every = INTERVAL_W'(255);
                end
                2:
                begin
                    numer = $urandom();
                    every = INTERVAL_W'(1);
                end
                3:
                begin
                    numer = $urandom_range(1000000, 99999999);
                    every = INTERVAL_W'($urandom_range(1, 255));
                end
                4:
                begin
                    numer = $urandom_range(0, 2000000);
                    every = INTERVAL_W'($urandom_range(1, 255));
                end
                default:
                begin
                    numer = $urandom();
                    every = INTERVAL_W'($urandom_range(0, 255));
                end
            endcase
            configure(numer, every);
            if (phase == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            repeat (ITEMS_PER_PHASE) send_ticks(random_ticks());
        end
    endtask

    initial
    begin
        numer_reg           = NUMER_RESET;
        interval_reg        = INTERVAL_RESET;
        prev_capture        = '0;
        pulses_since_update = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_capture_edges();
        test_numerator_extremes();
        test_display_interval();
        test_random_traffic();

        // Drain, then watch a while longer for any stray transfer
        wait_for_idle();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side ready: random low bursts between random high stretches
    always @(posedge clk)
    begin
        if (!idle_on)
            m_axis_tready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if (m_axis_tready)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 7);
            end
            else
                ready_hold = $urandom_range(0, 30);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end
    end

    task automatic check_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Each result transfer against the oldest predicted reading
    always @(posedge clk)
    begin
        speed_reading_t seen;
        speed_reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = speed_reading_t'(m_axis_tdata[READING_W-1:0]);
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer: expected none, actual %h", $time,
                         m_axis_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("speed_e4", 32'(want.speed_e4), 32'(seen.speed_e4));
                check_field("saturated", 32'(want.saturated), 32'(seen.saturated));
                check_field("tens_digit", 32'(want.tens), 32'(seen.tens));
                check_field("ones_digit", 32'(want.ones), 32'(seen.ones));
                check_field("tenths_digit", 32'(want.tenths), 32'(seen.tenths));
                check_field("hundredths_digit", 32'(want.hundredths),
                            32'(seen.hundredths));
                check_field("thousandths_digit", 32'(want.thousandths),
                            32'(seen.thousandths));
                check_field("myriadths_digit", 32'(want.myriadths), 32'(seen.myriadths));
                check_field("display_update", 32'(want.display_update),
                            32'(seen.display_update));
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> pulse_period_speed_meter_unit.f
rtl/pmu_pkg.sv
rtl/pmu_front.sv
rtl/pmu_queue.sv
rtl/pmu_back.sv
rtl/pulse_period_speed_meter_unit.sv
rtl/pmu_checker.sv
test/tb.sv
